@@ rtl/chte_pkg.sv @@
package chte_pkg;

  localparam int unsigned MaxBucketsDefault = 256;
  localparam int unsigned PoolNodesDefault  = 1024;

  localparam int unsigned CfgW   = 9;
  localparam int unsigned CountW = 11;
  localparam logic [CfgW-1:0] BucketCountReset = 9'd256;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_PURGE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] hash_value;
    logic [63:0] key_word;
    logic [63:0] value_word;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [63:0]       found_value;
    logic [CountW-1:0] entries_held;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_DISPATCH,
    S_INS_RD,
    S_INS_LINK,
    S_SRCH_RD,
    S_SRCH_NODE,
    S_PURGE_RD,
    S_PURGE_STEP,
    S_RESP
  } state_e;

endpackage

@@ rtl/chte_modulo.sv @@
// iterative remainder of a 64-bit hash by the bucket count, one bit per cycle
module chte_modulo #(
  parameter int unsigned DivW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [63:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  logic [63:0]   quot_q, quot_d;
  logic [DivW:0] rem_q, rem_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DivW:0] shifted;

  // shift in one dividend bit and subtract when possible
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[DivW-1:0], quot_q[63]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[62:0], 1'b0};
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = shifted - {1'b0, divisor_i};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = !busy_q && !start_i;
  assign rem_o  = rem_q[DivW-1:0];

endmodule

@@ rtl/chte_bucket_mem.sv @@
// bucket table: head and tail pointer per bucket, one read and one write port
module chte_bucket_mem #(
  parameter int unsigned MaxBuckets = chte_pkg::MaxBucketsDefault,
  parameter int unsigned PtrW       = 11
) (
  input  logic                          clk_i,
  input  logic [$clog2(MaxBuckets)-1:0] rd_addr_i,
  output logic [PtrW-1:0]               rd_head_o,
  output logic [PtrW-1:0]               rd_tail_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(MaxBuckets)-1:0] wr_addr_i,
  input  logic [PtrW-1:0]               wr_head_i,
  input  logic [PtrW-1:0]               wr_tail_i
);

  logic [2*PtrW-1:0] mem [MaxBuckets];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_head_i, wr_tail_i};
    end
    {rd_head_o, rd_tail_o} <= mem[rd_addr_i];
  end

endmodule

@@ rtl/chte_node_mem.sv @@
// node pool: key, value and link per node
module chte_node_mem #(
  parameter int unsigned PoolNodes = chte_pkg::PoolNodesDefault,
  parameter int unsigned PtrW      = 11
) (
  input  logic                         clk_i,
  input  logic [$clog2(PoolNodes)-1:0] rd_addr_i,
  output logic [63:0]                  rd_key_o,
  output logic [63:0]                  rd_value_o,
  output logic [PtrW-1:0]              rd_link_o,
  input  logic                         wr_node_i,
  input  logic                         wr_link_i,
  input  logic [$clog2(PoolNodes)-1:0] wr_addr_i,
  input  logic [63:0]                  wr_key_i,
  input  logic [63:0]                  wr_value_i,
  input  logic [PtrW-1:0]              wr_link_data_i
);

  logic [63:0]     key_mem [PoolNodes];
  logic [63:0]     val_mem [PoolNodes];
  logic [PtrW-1:0] lnk_mem [PoolNodes];

  always_ff @(posedge clk_i) begin
    if (wr_node_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_value_i;
    end
    if (wr_node_i || wr_link_i) begin
      lnk_mem[wr_addr_i] <= wr_link_data_i;
    end
    rd_key_o   <= key_mem[rd_addr_i];
    rd_value_o <= val_mem[rd_addr_i];
    rd_link_o  <= lnk_mem[rd_addr_i];
  end

endmodule

@@ rtl/chained_hash_table_engine_core.sv @@
// from request beat to response valid: insert and search first form the bit-serial remainder
// of the hash by the bucket count; insert then reads the bucket and links a node unless the
// pool is full; search reads the chain one node at a time; purge reads and empties every bucket;
// an idle action goes straight to the response; one request at a time, taken only while idle;
// a response beat still waiting stalls the engine only when the next response is ready
// reset: bucket table swept empty, one bucket per cycle, before any request
module chained_hash_table_engine_core #(
  parameter int unsigned MaxBuckets = chte_pkg::MaxBucketsDefault,
  parameter int unsigned PoolNodes  = chte_pkg::PoolNodesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  chte_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output chte_pkg::rsp_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [chte_pkg::CfgW-1:0]     cfg_data_i
);
  import chte_pkg::*;

  localparam int unsigned PtrW = $clog2(PoolNodes + 1);
  localparam int unsigned BW   = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned NW   = $clog2(PoolNodes);
  localparam int unsigned DivW = $clog2(MaxBuckets + 1);
  localparam logic [PtrW-1:0] Nil = PtrW'(PoolNodes);
  localparam logic [BW-1:0] LastBucket = BW'(MaxBuckets - 1);

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q, rsp_valid_d;
  status_e           stat_q, stat_d;
  logic [63:0]       found_q, found_d;
  logic [CfgW-1:0]   bcount_q;
  logic [BW-1:0]     bidx_q, bidx_d;
  logic [PtrW-1:0]   node_q, node_d;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0]   fhead_q, fhead_d, ftail_q, ftail_d;
  logic [PtrW-1:0]   fresh_q, fresh_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PtrW-1:0]   steps_q, steps_d;

  // effective bucket count
  logic [DivW-1:0] divisor;
  always_comb begin
    if (bcount_q == '0) begin
      divisor = DivW'(1);
    end else if (32'(bcount_q) > MaxBuckets) begin
      divisor = DivW'(MaxBuckets);
    end else begin
      divisor = DivW'(bcount_q);
    end
  end

  logic            mod_start, mod_done;
  logic [DivW-1:0] mod_rem;
  logic            in_fire;

  chte_modulo #(.DivW(DivW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(mod_start), .dividend_i(in_data_i.hash_value), .divisor_i(divisor),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  logic [BW-1:0]   b_rd_addr, b_wr_addr;
  logic [PtrW-1:0] b_rd_head, b_rd_tail, b_wr_head, b_wr_tail;
  logic            b_wr_en;

  chte_bucket_mem #(.MaxBuckets(MaxBuckets), .PtrW(PtrW)) u_bkt (
    .clk_i, .rd_addr_i(b_rd_addr), .rd_head_o(b_rd_head), .rd_tail_o(b_rd_tail),
    .wr_en_i(b_wr_en), .wr_addr_i(b_wr_addr), .wr_head_i(b_wr_head), .wr_tail_i(b_wr_tail)
  );

  logic [NW-1:0]   n_rd_addr, n_wr_addr;
  logic [63:0]     n_rd_key, n_rd_val;
  logic [PtrW-1:0] n_rd_link, n_wr_link;
  logic            n_wr_node, n_wr_lnk;

  chte_node_mem #(.PoolNodes(PoolNodes), .PtrW(PtrW)) u_node (
    .clk_i, .rd_addr_i(n_rd_addr), .rd_key_o(n_rd_key), .rd_value_o(n_rd_val),
    .rd_link_o(n_rd_link), .wr_node_i(n_wr_node), .wr_link_i(n_wr_lnk),
    .wr_addr_i(n_wr_addr), .wr_key_i(req_q.key_word), .wr_value_i(req_q.value_word),
    .wr_link_data_i(n_wr_link)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.action == ACT_PURGE) begin
            state_d = S_PURGE_RD;
          end else if (in_data_i.action == ACT_NONE) begin
            state_d = S_RESP;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_CLEAR: if (bidx_q == LastBucket) state_d = S_IDLE;
      S_MOD: if (mod_done) state_d = S_DISPATCH;
      S_DISPATCH: state_d = (req_q.action == ACT_INSERT) ? S_INS_RD : S_SRCH_RD;
      S_INS_RD: state_d = (fhead_q >= Nil && fresh_q >= Nil) ? S_RESP : S_INS_LINK;
      S_INS_LINK: state_d = S_RESP;
      S_SRCH_RD: state_d = S_SRCH_NODE;
      S_SRCH_NODE: begin
        if (node_q >= Nil || steps_q == PtrW'(PoolNodes) || n_rd_key == req_q.key_word) begin
          state_d = S_RESP;
        end
      end
      S_PURGE_RD: state_d = S_PURGE_STEP;
      S_PURGE_STEP: state_d = (bidx_q == LastBucket) ? S_RESP : S_PURGE_RD;
      S_RESP: if (!rsp_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    rsp_d = rsp_q;  rsp_valid_d = rsp_valid_q;
    stat_d = stat_q; found_d = found_q;
    bidx_d = bidx_q; node_d = node_q; head_d = head_q; tail_d = tail_q;
    fhead_d = fhead_q; ftail_d = ftail_q; fresh_d = fresh_q;
    count_d = count_q; steps_d = steps_q;
    mod_start = in_fire && (in_data_i.action == ACT_INSERT ||
                            in_data_i.action == ACT_SEARCH);
    b_rd_addr = bidx_q; b_wr_addr = bidx_q; b_wr_en = 1'b0;
    b_wr_head = Nil; b_wr_tail = Nil;
    n_rd_addr = fhead_q[NW-1:0]; n_wr_addr = node_q[NW-1:0];
    n_wr_node = 1'b0; n_wr_lnk = 1'b0; n_wr_link = Nil;
    if (rsp_valid_q && out_ready_i) rsp_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        bidx_d  = '0;
        stat_d  = ST_OK;
        found_d = '0;
      end
      S_CLEAR: begin
        b_wr_en = 1'b1;
        bidx_d  = bidx_q + BW'(1);
      end
      S_MOD: begin
        bidx_d = BW'(mod_rem);
      end
      S_DISPATCH: begin
        // read bucket, and for insert the free list head's link
        b_rd_addr = bidx_q;
        n_rd_addr = fhead_q[NW-1:0];
      end
      S_INS_RD: begin
        if (fhead_q < Nil) begin
          node_d  = fhead_q;
          fhead_d = (n_rd_link >= Nil) ? Nil : n_rd_link;
          if (n_rd_link >= Nil) ftail_d = Nil;
        end else if (fresh_q < Nil) begin
          node_d  = fresh_q;
          fresh_d = fresh_q + PtrW'(1);
        end else begin
          stat_d = ST_FULL;
        end
        head_d = b_rd_head; tail_d = b_rd_tail;
      end
      S_INS_LINK: begin
        // write the new node and the bucket, the old tail is linked in resp
        n_wr_node = 1'b1; n_wr_addr = node_q[NW-1:0]; n_wr_link = Nil;
        b_wr_en = 1'b1;
        b_wr_head = (tail_q < Nil) ? head_q : node_q;
        b_wr_tail = node_q;
        count_d = count_q + CountW'(1);
      end
      S_SRCH_RD: begin
        node_d = b_rd_head; steps_d = '0;
        n_rd_addr = b_rd_head[NW-1:0];
        stat_d = ST_MISS;
      end
      S_SRCH_NODE: begin
        if (node_q < Nil && steps_q != PtrW'(PoolNodes)) begin
          if (n_rd_key == req_q.key_word) begin
            stat_d = ST_OK; found_d = n_rd_val;
          end else begin
            node_d = n_rd_link; steps_d = steps_q + PtrW'(1);
            n_rd_addr = n_rd_link[NW-1:0];
          end
        end
      end
      S_PURGE_RD: begin
        b_rd_addr = bidx_q;
      end
      S_PURGE_STEP: begin
        b_wr_en = 1'b1;
        if (b_rd_head < Nil && b_rd_tail < Nil) begin
          if (fhead_q < Nil && ftail_q < Nil) begin
            n_wr_lnk = 1'b1; n_wr_addr = ftail_q[NW-1:0]; n_wr_link = b_rd_head;
          end else begin
            fhead_d = b_rd_head;
          end
          ftail_d = b_rd_tail;
        end
        bidx_d = bidx_q + BW'(1);
        count_d = '0;
      end
      S_RESP: begin
        // append link from old tail after an insert
        if (req_q.action == ACT_INSERT && stat_q != ST_FULL && tail_q < Nil) begin
          n_wr_lnk = 1'b1; n_wr_addr = tail_q[NW-1:0]; n_wr_link = node_q;
        end
        // load the response register once it is free
        if (!rsp_valid_q || out_ready_i) begin
          rsp_d.status       = stat_q;
          rsp_d.found_value  = found_q;
          rsp_d.entries_held = count_q;
          rsp_valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
      bcount_q    <= BucketCountReset;
      bidx_q      <= '0;
      fhead_q     <= Nil;
      ftail_q     <= Nil;
      fresh_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) bcount_q <= cfg_data_i;
      bidx_q      <= bidx_d;
      fhead_q     <= fhead_d;
      ftail_q     <= ftail_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_data_i;
    rsp_q   <= rsp_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    node_q  <= node_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    steps_q <= steps_d;
  end

  // the entry count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CountW'(PoolNodes))
    else $error("entry count beyond pool");
  // a waiting response beat holds steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("response beat changed while waiting");
  // a purge answers with an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && req_q.action == ACT_PURGE) |-> count_q == '0)
    else $error("purge left entries");

endmodule

@@ bench/tb_chained_hash_table_engine_core.sv @@
`timescale 1ns / 100ps

module tb_chained_hash_table_engine_core;
  import chte_pkg::*;

  localparam int unsigned Buckets = 256;
  localparam int unsigned Nodes   = 1024;
  localparam logic [10:0] Empty   = 11'd1024;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  req_t           in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  rsp_t           out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i;

  chained_hash_table_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow table
  logic [CfgW-1:0] shadow_buckets;
  logic [10:0]     shadow_head [Buckets];
  logic [10:0]     shadow_tail [Buckets];
  logic [63:0]     shadow_key  [Nodes];
  logic [63:0]     shadow_val  [Nodes];
  logic [10:0]     shadow_link [Nodes];
  logic [10:0]     spare_head;
  logic [10:0]     spare_tail;
  logic [10:0]     unused_cursor;
  logic [10:0]     held_count;

  req_t   request_q [$];
  rsp_t   answer_q [$];
  logic [63:0] seen_hash [$];
  logic [63:0] seen_key [$];
  int     mismatches;
  bit     in_taken;
  int     in_gap;
  int     out_stall;

  function automatic int unsigned bucket_for(logic [63:0] hash);
    logic [63:0] n;
    n = 64'(shadow_buckets);
    if (n == 64'd0) n = 64'd1;
    if (n > 64'(Buckets)) n = 64'(Buckets);
    return int'(hash % n);
  endfunction

  task automatic table_apply(input req_t r, output rsp_t a);
    int unsigned b;
    logic [10:0] n;
    int steps;
    a = '0;
    a.status = ST_OK;
    case (action_e'(r.action))
      ACT_INSERT: begin
        // free list first, then untouched nodes
        n = Empty;
        if (spare_head < Empty) begin
          n = spare_head;
          spare_head = shadow_link[n];
          if (spare_head >= Empty) begin
            spare_head = Empty;
            spare_tail = Empty;
          end
        end else if (unused_cursor < Empty) begin
          n = unused_cursor;
          unused_cursor++;
        end
        if (n >= Empty) begin
          a.status = ST_FULL;
        end else begin
          b = bucket_for(r.hash_value);
          shadow_key[n]  = r.key_word;
          shadow_val[n]  = r.value_word;
          shadow_link[n] = Empty;
          if (shadow_tail[b] < Empty) shadow_link[shadow_tail[b]] = n;
          else shadow_head[b] = n;
          shadow_tail[b] = n;
          held_count++;
        end
      end
      ACT_SEARCH: begin
        b = bucket_for(r.hash_value);
        n = shadow_head[b];
        steps = 0;
        a.status = ST_MISS;
        while (n < Empty && steps < Nodes) begin
          if (shadow_key[n] == r.key_word) begin
            a.status = ST_OK;
            a.found_value = shadow_val[n];
            break;
          end
          n = shadow_link[n];
          steps++;
        end
      end
      ACT_PURGE: begin
        for (int i = 0; i < Buckets; i++) begin
          if (shadow_head[i] < Empty && shadow_tail[i] < Empty) begin
            if (spare_head < Empty && spare_tail < Empty) shadow_link[spare_tail] = shadow_head[i];
            else spare_head = shadow_head[i];
            spare_tail = shadow_tail[i];
          end
          shadow_head[i] = Empty;
          shadow_tail[i] = Empty;
        end
        held_count = '0;
      end
      default: ;
    endcase
    a.entries_held = held_count;
  endtask

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h at %0t", field, want, got, $time);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // accepted request beats feed the shadow table
  always @(posedge clk_i) begin
    rsp_t a;
    if (rst_ni && in_valid_i && in_ready_o) begin
      table_apply(in_data_i, a);
      answer_q.push_back(a);
      in_taken = 1'b1;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_data_i  <= request_q.pop_front();
        in_valid_i <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(99) < 15) out_stall = pick_gap();
    end
  end

  // response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_data_o.found_value);
      end else begin
        want = answer_q.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_data_o.status));
        if (out_data_o.found_value !== want.found_value)
          report_mismatch("found_value", want.found_value, out_data_o.found_value);
        if (out_data_o.entries_held !== want.entries_held)
          report_mismatch("entries_held", 64'(want.entries_held),
                          64'(out_data_o.entries_held));
      end
    end
  end

  task automatic push_req(action_e act, logic [63:0] h, logic [63:0] k, logic [63:0] v);
    req_t r;
    r.action     = act;
    r.hash_value = h;
    r.key_word   = k;
    r.value_word = v;
    request_q.push_back(r);
  endtask

  // mixed traffic; searches mostly aim at keys already inserted
  task automatic push_random(int purge_pct);
    int r;
    int j;
    logic [63:0] h;
    logic [63:0] k;
    r = $urandom_range(99);
    h = rand64();
    k = rand64();
    if (seen_key.size() > 0 && $urandom_range(99) < 60) begin
      j = $urandom_range(seen_key.size() - 1);
      h = seen_hash[j];
      k = seen_key[j];
    end
    if (r < 2) begin
      push_req(ACT_NONE, h, k, rand64());
    end else if (r < 2 + purge_pct) begin
      push_req(ACT_PURGE, h, k, rand64());
    end else if (r < 55) begin
      push_req(ACT_INSERT, h, k, rand64());
      if (seen_key.size() >= 64) begin
        seen_key.delete(0);
        seen_hash.delete(0);
      end
      seen_key.push_back(k);
      seen_hash.push_back(h);
    end else begin
      push_req(ACT_SEARCH, h, k, rand64());
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (request_q.size() > 0 || in_valid_i || answer_q.size() > 0);
  endtask

  task automatic write_buckets(logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    shadow_buckets = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    mismatches  = 0;
    in_taken    = 1'b0;
    in_gap      = 0;
    out_stall   = 0;
    shadow_buckets = BucketCountReset;
    for (int i = 0; i < Buckets; i++) begin
      shadow_head[i] = Empty;
      shadow_tail[i] = Empty;
    end
    for (int i = 0; i < Nodes; i++) shadow_link[i] = Empty;
    spare_head    = Empty;
    spare_tail    = Empty;
    unused_cursor = '0;
    held_count    = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, duplicates, miss, idle action, purge and reuse
    write_buckets(9'd256);
    push_req(ACT_SEARCH, 64'd0, 64'd0, 64'd0);
    push_req(ACT_INSERT, 64'd0, 64'd0, 64'd0);
    push_req(ACT_INSERT, '1, '1, '1);
    push_req(ACT_INSERT, 64'd256, 64'd0, 64'd5);
    push_req(ACT_SEARCH, 64'd0, 64'd0, '1);
    push_req(ACT_SEARCH, '1, '1, 64'd0);
    push_req(ACT_SEARCH, 64'd512, 64'd123, 64'd0);
    push_req(ACT_NONE, rand64(), rand64(), rand64());
    push_req(ACT_PURGE, '1, '1, '1);
    push_req(ACT_SEARCH, 64'd0, 64'd0, 64'd0);
    push_req(ACT_INSERT, 64'd7, 64'd9, 64'ha5a5_a5a5_a5a5_a5a5);
    push_req(ACT_SEARCH, 64'd7, 64'd9, 64'd0);
    push_req(ACT_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
             64'haaaa_aaaa_aaaa_aaaa);
    push_req(ACT_SEARCH, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'd0);
    push_req(ACT_PURGE, 64'd0, 64'd0, 64'd0);
    drain();

    // single chain
    write_buckets(9'd1);
    repeat (200) push_random(4);
    drain();

    // modulus changed with entries still held; above range acts as the maximum
    write_buckets(9'd511);
    repeat (150) push_random(0);
    push_req(ACT_PURGE, rand64(), rand64(), rand64());
    // fill the pool and run past it
    for (int i = 0; i < 1100; i++) begin
      if (i % 20 == 19) push_random(0);
      else push_req(ACT_INSERT, rand64(), rand64(), rand64());
    end
    push_req(ACT_PURGE, rand64(), rand64(), rand64());
    drain();

    // zero acts as one bucket
    write_buckets(9'd0);
    repeat (100) push_random(5);
    drain();

    write_buckets(CfgW'($urandom_range(2, 255)));
    repeat (150) push_random(3);
    drain();

    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("chained_hash_table_engine_core test passed");
    end else begin
      $display("chained_hash_table_engine_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("chained_hash_table_engine_core test failed");
    $finish;
  end

endmodule

@@ chained_hash_table_engine_core.f @@
rtl/chte_pkg.sv
rtl/chte_modulo.sv
rtl/chte_bucket_mem.sv
rtl/chte_node_mem.sv
rtl/chained_hash_table_engine_core.sv
bench/tb_chained_hash_table_engine_core.sv
